/* hdl/tsr_pkg.sv */
// ----------------------------------------------------------------------------
// Tagged sample resampler package
// Field widths, interface packing, parameter defaults and operation codes
// that are shared by the resampler modules.
// ----------------------------------------------------------------------------
package tsr_pkg;

  // Field widths of one transaction.
  localparam int TS_W     = 48;
  localparam int SMP_W    = 14;
  localparam int BYTE_W   = 8;
  localparam int VOL_W    = 7;
  localparam int METHOD_W = 2;

  // Magnitude of a sample difference, also the quotient width of the divide.
  localparam int MAG_W = SMP_W + 1;

  // Stream packing, rounded up to whole bytes.
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 16;

  // Parameter defaults.
  localparam int RING_DEPTH_DEF = 256;
  localparam int TIME_BITS_DEF  = 48;

  // Operation carried in the input tuser bit.
  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  // Resampling method; the last code selects linear interpolation as well.
  typedef enum logic [METHOD_W-1:0] {
    METHOD_HOLD       = 2'd0,
    METHOD_NEAREST    = 2'd1,
    METHOD_LINEAR     = 2'd2,
    METHOD_LINEAR_ALT = 2'd3
  } method_t;

endpackage

/* hdl/tsr_alu.sv */
// ----------------------------------------------------------------------------
// Tagged sample resampler shared adder
// One add/subtract unit used by the sequencer for every tag compare, time
// difference, shift-add multiply step and restoring divide step.
// ----------------------------------------------------------------------------
module tsr_alu #(
  parameter int W = 63
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] y,
  output logic         co
);

  logic [W:0] sum;

  // Subtraction is a + ~b + 1; the carry out is set when a >= b.
  assign sum = {1'b0, a} + {1'b0, b ^ {W{sub}}} + (W+1)'(sub);
  assign y   = sum[W-1:0];
  assign co  = sum[W];

endmodule

/* hdl/tagged_sample_resampler.sv */
// A push passes through ST_PUSH and ST_DONE after the transaction is accepted.
// A query spends ST_WALK_RD and ST_WALK_CHK on each ring entry it discards and
// ends at ST_DONE; hold and nearest add their compare steps, and linear
// interpolation adds the 15-step multiply and 15-step divide on the shared adder.
// One item is in work at a time; the next is accepted after the result is stored.
// Reset (synchronous, active low) leaves one entry with tag 0 and sample 0.
// ----------------------------------------------------------------------------
// Tagged sample resampler
// Ring of time-tagged, volume-scaled samples with a query port that answers
// by hold, nearest neighbor or linear interpolation, using one shared adder.
// ----------------------------------------------------------------------------
module tagged_sample_resampler import tsr_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [47:0] time_stamp, [55:48] sample_byte, [62:56] volume
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [0] opcode
  input  logic [0:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [13:0] sample_out
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // [0] push_dropped
  output logic [0:0]             out_tuser,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [METHOD_W-1:0]    cfg_data
);

  localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int W  = TIME_BITS + MAG_W;
  localparam int CW = $clog2(MAG_W);
  localparam int PW = BYTE_W + VOL_W + 1;
  localparam logic [IW-1:0] IDX_LAST = IW'(RING_DEPTH - 1);
  localparam logic [CW-1:0] CNT_TOP  = CW'(MAG_W - 1);
  localparam logic signed [PW-1:0] SAT_MAX = PW'((2 ** (SMP_W - 1)) - 1);
  localparam logic signed [PW-1:0] SAT_MIN = PW'(-(2 ** (SMP_W - 1)));
  localparam logic signed [MAG_W:0] K_ONE  = (MAG_W+1)'(1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_T_SUB,
    ST_NR_SUB,
    ST_NR_CMP,
    ST_DX_SUB,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_DONE
  } state_t;

  function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] i);
    return (i == IDX_LAST) ? '0 : IW'(i + 1'b1);
  endfunction

  state_t                   state_r;
  method_t                  method_r;
  logic [IW-1:0]            rd_idx_r;
  logic [IW-1:0]            wr_idx_r;
  logic [TIME_BITS-1:0]     front_tag_r;
  logic signed [SMP_W-1:0]  front_smp_r;
  logic [TIME_BITS-1:0]     c2_r;
  logic signed [SMP_W-1:0]  s2_r;
  logic [TIME_BITS-1:0]     clk_r;
  logic signed [BYTE_W-1:0] byte_r;
  logic [VOL_W-1:0]         vol_r;
  logic [W-1:0]             t_r;
  logic [W-1:0]             dx_r;
  logic [W-1:0]             acc_r;
  logic [MAG_W-1:0]         q_r;
  logic [CW-1:0]            cnt_r;
  logic signed [SMP_W-1:0]  res_r;
  logic                     drop_r;
  logic signed [SMP_W-1:0]  out_smp_r;
  logic                     out_drop_r;
  logic                     out_valid_r;

  // Sample ring storage with a registered read port.
  logic [TIME_BITS-1:0]     tag_mem [RING_DEPTH];
  logic signed [SMP_W-1:0]  smp_mem [RING_DEPTH];
  logic [TIME_BITS-1:0]     rd_tag_r;
  logic signed [SMP_W-1:0]  rd_smp_r;

  logic [IW-1:0]            r2_idx;
  logic [IW-1:0]            wr_next;
  logic                     ring_full;
  logic [TS_W-1:0]          in_time;
  logic signed [PW-1:0]     prod;
  logic signed [SMP_W-1:0]  sat_smp;
  logic signed [MAG_W-1:0]  dy;
  logic [MAG_W-1:0]         mag;
  logic signed [MAG_W:0]    s1x;
  logic signed [MAG_W:0]    qx;
  logic signed [MAG_W:0]    kpos;
  logic signed [MAG_W:0]    kneg;
  logic signed [MAG_W:0]    kfix;
  logic                     rem_nz;
  logic [W-1:0]             alu_a;
  logic [W-1:0]             alu_b;
  logic                     alu_sub;
  logic [W-1:0]             alu_y;
  logic                     alu_co;

  // Ring pointers and the full condition.
  assign r2_idx    = ring_next(rd_idx_r);
  assign wr_next   = ring_next(wr_idx_r);
  assign ring_full = (wr_next == rd_idx_r);

  // Volume scaling and saturation of a pushed sample.
  assign in_time = in_tdata[TS_W-1:0];
  assign prod    = byte_r * $signed({1'b0, vol_r});
  always_comb begin
    if (prod > SAT_MAX) begin
      sat_smp = SMP_W'(SAT_MAX);
    end else if (prod < SAT_MIN) begin
      sat_smp = SMP_W'(SAT_MIN);
    end else begin
      sat_smp = SMP_W'(prod);
    end
  end

  // Slope magnitude of the two front entries.
  assign dy  = $signed({s2_r[SMP_W-1], s2_r}) - $signed({front_smp_r[SMP_W-1], front_smp_r});
  assign mag = dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);

  // Apply the quotient to the front sample, rounding toward zero.
  assign s1x    = (MAG_W+1)'(front_smp_r);
  assign qx     = $signed({1'b0, q_r});
  assign kpos   = s1x + qx;
  assign kneg   = s1x - qx;
  assign rem_nz = (acc_r != '0);
  always_comb begin
    if (!dy[MAG_W-1]) begin
      kfix = (kpos < 0 && rem_nz) ? kpos + K_ONE : kpos;
    end else begin
      kfix = (kneg > 0 && rem_nz) ? kneg - K_ONE : kneg;
    end
  end

  // Operand selection for the shared adder.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;
    unique case (state_r)
      ST_WALK_CHK: begin
        alu_a = W'(clk_r);
        alu_b = W'(rd_tag_r);
      end
      ST_T_SUB: begin
        alu_a = W'(clk_r);
        alu_b = W'(front_tag_r);
      end
      ST_NR_SUB: begin
        alu_a = W'(c2_r);
        alu_b = W'(clk_r);
      end
      ST_NR_CMP: begin
        alu_a = t_r;
        alu_b = dx_r;
      end
      ST_DX_SUB: begin
        alu_a = W'(c2_r);
        alu_b = W'(front_tag_r);
      end
      ST_MUL: begin
        alu_a   = {acc_r[W-2:0], 1'b0};
        alu_b   = mag[cnt_r] ? t_r : '0;
        alu_sub = 1'b0;
      end
      ST_DIV: begin
        alu_a = acc_r;
        alu_b = dx_r;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  tsr_alu #(
    .W (W)
  ) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .y   (alu_y),
    .co  (alu_co)
  );

  // Ring write on an accepted push and registered read of the successor entry.
  always_ff @(posedge clk) begin
    if (state_r == ST_PUSH && !ring_full) begin
      tag_mem[wr_idx_r] <= clk_r;
      smp_mem[wr_idx_r] <= sat_smp;
    end
    rd_tag_r <= tag_mem[r2_idx];
    rd_smp_r <= smp_mem[r2_idx];
  end

  // Sequencer: push, walk, compare, multiply and divide steps, then the result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      method_r    <= METHOD_HOLD;
      rd_idx_r    <= '0;
      wr_idx_r    <= IW'(1);
      front_tag_r <= '0;
      front_smp_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        method_r <= method_t'(cfg_data);
      end
      // A result that is taken empties the output register unless the next
      // one is loaded in the same cycle.
      if (out_valid_r && out_tready && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            clk_r  <= TIME_BITS'(in_time);
            byte_r <= in_tdata[TS_W +: BYTE_W];
            vol_r  <= in_tdata[TS_W+BYTE_W +: VOL_W];
            state_r <= (opcode_t'(in_tuser[0]) == OP_QUERY) ? ST_WALK_RD : ST_PUSH;
          end
        end
        ST_PUSH: begin
          drop_r <= ring_full;
          res_r  <= '0;
          if (!ring_full) begin
            wr_idx_r <= wr_next;
          end
          state_r <= ST_DONE;
        end
        ST_WALK_RD: begin
          drop_r <= 1'b0;
          if (r2_idx == wr_idx_r) begin
            res_r   <= front_smp_r;
            state_r <= ST_DONE;
          end else begin
            state_r <= ST_WALK_CHK;
          end
        end
        ST_WALK_CHK: begin
          if (alu_co) begin
            rd_idx_r    <= r2_idx;
            front_tag_r <= rd_tag_r;
            front_smp_r <= rd_smp_r;
            state_r     <= ST_WALK_RD;
          end else begin
            c2_r    <= rd_tag_r;
            s2_r    <= rd_smp_r;
            state_r <= ST_T_SUB;
          end
        end
        ST_T_SUB: begin
          t_r <= alu_y;
          if (!alu_co || method_r == METHOD_HOLD) begin
            res_r   <= front_smp_r;
            state_r <= ST_DONE;
          end else if (method_r == METHOD_NEAREST) begin
            state_r <= ST_NR_SUB;
          end else begin
            state_r <= ST_DX_SUB;
          end
        end
        ST_NR_SUB: begin
          dx_r    <= alu_y;
          state_r <= ST_NR_CMP;
        end
        ST_NR_CMP: begin
          res_r   <= alu_co ? s2_r : front_smp_r;
          state_r <= ST_DONE;
        end
        ST_DX_SUB: begin
          dx_r    <= alu_y << (MAG_W - 1);
          acc_r   <= '0;
          cnt_r   <= CNT_TOP;
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          acc_r <= alu_y;
          if (cnt_r == '0) begin
            cnt_r   <= CNT_TOP;
            state_r <= ST_DIV;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        ST_DIV: begin
          if (alu_co) begin
            acc_r <= alu_y;
          end
          q_r[cnt_r] <= alu_co;
          dx_r       <= dx_r >> 1;
          if (cnt_r == '0) begin
            state_r <= ST_FIN;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        ST_FIN: begin
          res_r   <= SMP_W'(kfix);
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_smp_r   <= res_r;
            out_drop_r  <= drop_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-SMP_W){1'b0}}, out_smp_r};
  assign out_tuser  = out_drop_r;

  // The read end never catches up with the write end.
  a_ring_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    rd_idx_r != wr_idx_r)
    else $error("ring read index reached write index");

  // An entry is only examined while it lies before the write end.
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK_CHK |-> r2_idx != wr_idx_r)
    else $error("walk examined an unwritten entry");

  // Each divide step keeps the partial remainder below twice the divisor.
  a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> {1'b0, acc_r} < {dx_r, 1'b0})
    else $error("divide remainder out of range");

  // A dropped push always reports a zero sample.
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_drop_r |-> out_smp_r == '0)
    else $error("dropped push with nonzero sample");

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// Tagged sample resampler testbench
// Drives pushes and queries into the resampler over its input stream and
// checks every result against a cycle-free model of the sample ring. The
// model tracks the ring, the read and write positions and the resampling
// method. A directed sequence covers saturation, out-of-order tags, single
// entries, tie-breaking and wide interpolation spans. Random traffic then runs
// under every method, with varied stalls and one ring-filling burst.
// ----------------------------------------------------------------------------
module tb_top import tsr_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = RING_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 60;

  // One push or query as it goes into the stream.
  typedef struct {
    opcode_t                  op;
    logic [TS_W-1:0]          stamp;
    logic signed [BYTE_W-1:0] smp;
    logic [VOL_W-1:0]         vol;
  } audio_item_t;

  // One expected answer.
  typedef struct {
    logic signed [SMP_W-1:0] value;
    logic                    dropped;
  } resample_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [0:0]             in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [0:0]             out_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [METHOD_W-1:0]    cfg_data = '0;

  audio_item_t      pending_items[$];
  resample_result_t expected_results[$];
  resample_result_t want_res;

  // Shadow copy of the ring and its settings.
  logic [TS_W-1:0]         tag_mem [DEPTH];
  logic signed [SMP_W-1:0] val_mem [DEPTH];
  int unsigned             rd_idx;
  int unsigned             wr_idx;
  method_t                 method_cur;

  int   err_count = 0;
  int   cycle_count = 0;
  int   send_idle_pct = 16;
  int   recv_idle_pct = 68;
  logic rx_hold = 1'b0;
  logic hold_go = 1'b0;

  logic [TS_W-1:0] push_clk;
  logic [TS_W-1:0] qry_clk;

  tagged_sample_resampler dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Clock with a 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Applies one accepted item to the shadow ring and returns its answer.
  function automatic resample_result_t predict_resample(audio_item_t it);
    resample_result_t    r;
    int                  sv;
    int                  vv;
    int                  prod;
    int unsigned         a;
    int unsigned         b;
    logic [TS_W-1:0]     c1;
    logic [TS_W-1:0]     c2;
    logic signed [SMP_W-1:0] s1;
    logic signed [SMP_W-1:0] s2;
    logic signed [127:0] num;
    logic signed [127:0] den;
    logic signed [127:0] quo;
    r.value = '0;
    r.dropped = 1'b0;
    if (it.op == OP_PUSH) begin
      sv = it.smp;
      vv = it.vol;
      prod = sv * vv;
      if (prod > 8191) prod = 8191;
      if (prod < -8192) prod = -8192;
      if ((wr_idx + 1) % DEPTH == rd_idx) begin
        r.dropped = 1'b1;
      end else begin
        tag_mem[wr_idx] = it.stamp;
        val_mem[wr_idx] = SMP_W'(prod);
        wr_idx = (wr_idx + 1) % DEPTH;
      end
    end else begin
      // Discard front entries whose successor is already due.
      a = rd_idx;
      b = (a + 1) % DEPTH;
      while (b != wr_idx && tag_mem[b] <= it.stamp) begin
        a = b;
        b = (a + 1) % DEPTH;
      end
      rd_idx = a;
      s1 = val_mem[a];
      c1 = tag_mem[a];
      c2 = tag_mem[b];
      s2 = val_mem[b];
      if (b == wr_idx || it.stamp < c1 || method_cur == METHOD_HOLD) begin
        r.value = s1;
      end else if (method_cur == METHOD_NEAREST) begin
        r.value = (it.stamp - c1 < c2 - it.stamp) ? s1 : s2;
      end else begin
        // Exact interpolation, truncated toward zero.
        den = $signed({80'd0, c2 - c1});
        num = s1 * den + $signed({80'd0, it.stamp - c1}) * (s2 - s1);
        quo = num / den;
        r.value = quo[SMP_W-1:0];
      end
    end
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    err_count++;
  endtask

  task automatic add_item(opcode_t op, logic [TS_W-1:0] ts, int smp, int vol);
    audio_item_t it;
    it.op = op;
    it.stamp = ts;
    it.smp = BYTE_W'(smp);
    it.vol = VOL_W'(vol);
    pending_items.push_back(it);
  endtask

  // Returns once every queued transaction has been answered.
  task automatic wait_idle();
    @(negedge clk);
    while (pending_items.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_method(method_t m);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    method_cur = m;
  endtask

  // Mostly ordered pushes and trailing queries, with some noise mixed in.
  task automatic gen_mixed(int n);
    int pick;
    int vol;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      vol = ($urandom_range(99) < 80) ? $urandom_range(64) : $urandom_range(127, 65);
      if (pick < 45) begin
        if ($urandom_range(9) == 0) begin
          add_item(OP_PUSH, push_clk - $urandom_range(100, 1), $urandom_range(255), vol);
        end else begin
          push_clk = push_clk + $urandom_range(40, 1);
          add_item(OP_PUSH, push_clk, $urandom_range(255), vol);
        end
      end else if (pick < 90) begin
        qry_clk = qry_clk + $urandom_range(30);
        if (qry_clk > push_clk + 20) qry_clk = push_clk - $urandom_range(40);
        add_item(OP_QUERY, qry_clk, $urandom_range(255), vol);
      end else begin
        add_item(opcode_t'($urandom_range(1)), TS_W'({$urandom(), $urandom()}),
                 $urandom_range(255), vol);
      end
    end
  endtask

  // One random stretch: new method, new stall mix, ring collapsed first.
  task automatic run_segment(method_t m, int s_idle, int r_idle, int n);
    wait_idle();
    write_method(m);
    @(negedge clk);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    add_item(OP_QUERY, '1, $urandom_range(255), $urandom_range(127));
    gen_mixed(n);
  endtask

  // Input driver: presents the oldest pending item and predicts on acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(predict_resample(pending_items.pop_front()));
      end
      if (!in_tvalid || in_tready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata <= {1'b0, pending_items[0].vol, pending_items[0].smp,
                       pending_items[0].stamp};
          in_tuser <= pending_items[0].op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each transaction against the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          flag_mismatch($sformatf("result with nothing expected, sample_out %0d",
                                  $signed(out_tdata[SMP_W-1:0])));
        end else begin
          want_res = expected_results.pop_front();
          if (out_tdata[SMP_W-1:0] !== want_res.value)
            flag_mismatch($sformatf("sample_out got %0d want %0d",
                                    $signed(out_tdata[SMP_W-1:0]), want_res.value));
          if (out_tuser[0] !== want_res.dropped)
            flag_mismatch($sformatf("push_dropped got %b want %b",
                                    out_tuser[0], want_res.dropped));
        end
      end
      out_tready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Long receiver hold-off so the block backs up into its input.
  initial begin
    wait (hold_go);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    rx_hold = 1'b0;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      tag_mem[i] = '0;
      val_mem[i] = '0;
    end
    rd_idx = 0;
    wr_idx = 1;
    method_cur = METHOD_HOLD;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Nearest neighbor: single entry, the two sides of a tie, then a discard.
    write_method(METHOD_NEAREST);
    @(negedge clk);
    add_item(OP_QUERY, 48'd0, 0, 0);
    add_item(OP_PUSH, 48'd20, 100, 1);
    add_item(OP_QUERY, 48'd9, 0, 0);
    add_item(OP_QUERY, 48'd10, 0, 0);
    add_item(OP_QUERY, 48'd20, 0, 0);
    wait_idle();

    // Linear: saturation both ways, rounding toward zero, out-of-order tags,
    // instant before the front tag and a span across the whole time range.
    write_method(METHOD_LINEAR);
    @(negedge clk);
    add_item(OP_PUSH, 48'd100, -128, 64);
    add_item(OP_PUSH, 48'd200, 127, 127);
    add_item(OP_PUSH, 48'd300, -128, 127);
    add_item(OP_PUSH, 48'd400, 0, 0);
    add_item(OP_QUERY, 48'd50, 0, 0);
    add_item(OP_QUERY, 48'd150, 0, 0);
    add_item(OP_QUERY, 48'd299, 0, 0);
    add_item(OP_PUSH, 48'd350, 1, 1);
    add_item(OP_QUERY, '1, 255, 127);
    add_item(OP_PUSH, 48'd1000, 5, 3);
    add_item(OP_QUERY, 48'd10, 0, 0);
    add_item(OP_PUSH, '1, 127, 64);
    add_item(OP_QUERY, 48'hFFFF_FFFF_FFFE, 0, 0);
    add_item(OP_QUERY, 48'd5000, 0, 0);
    add_item(OP_PUSH, 48'd0, -1, 127);
    add_item(OP_QUERY, 48'd1, 0, 0);

    push_clk = 48'd100000;
    qry_clk = 48'd100000;
    run_segment(METHOD_HOLD, 16, 68, 35);
    run_segment(METHOD_NEAREST, 16, 68, 35);
    run_segment(METHOD_LINEAR_ALT, 68, 16, 35);

    // Fill the ring past its capacity while the receiver holds off, then
    // walk the queries through the stored span.
    wait_idle();
    write_method(METHOD_LINEAR);
    @(negedge clk);
    add_item(OP_QUERY, '1, 0, 0);
    qry_clk = push_clk;
    for (int i = 0; i < 260; i++) begin
      push_clk = push_clk + $urandom_range(20, 1);
      add_item(OP_PUSH, push_clk, $urandom_range(255), $urandom_range(64));
    end
    hold_go = 1'b1;
    for (int i = 0; i < 20; i++) begin
      qry_clk = qry_clk + $urandom_range(300, 1);
      add_item(OP_QUERY, qry_clk, $urandom_range(255), $urandom_range(127));
    end

    run_segment(METHOD_LINEAR, 0, 0, 35);

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/tsr_pkg.sv
hdl/tsr_alu.sv
hdl/tagged_sample_resampler.sv
dv/tb_top.sv
